>>> hw/rtl/lcd_scanline_mode_sequencer_top_defines.svh
// Assertion macros used by the LCD scanline mode sequencer core (lsms_core).
// Expects signals named clk and rst in the scope of each use.
`ifndef LCD_SCANLINE_MODE_SEQUENCER_TOP_DEFINES_SVH
`define LCD_SCANLINE_MODE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSMS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lsms_pkg.sv
// Shared types, timing constants and mode decode for the LCD scanline mode sequencer.
// No dependencies.
package lsms_pkg;

  localparam int unsigned DotsOam         = 80;
  localparam int unsigned DotsXfer        = 172;
  localparam int unsigned DotsHblank      = 204;
  localparam int unsigned DotsLine        = DotsOam + DotsXfer + DotsHblank;
  localparam int unsigned FirstVblankLine = 144;
  localparam int unsigned LinesPerFrame   = 154;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic       match_irq_enable;
    logic       hblank_irq_enable;
    logic       oam_irq_enable;
    logic [7:0] compare_line;
    logic       lcd_on;
    logic [7:0] elapsed_cycles;
  } item_t;

  function automatic mode_t mode_for(input logic [7:0] line, input logic [8:0] dots);
    mode_t m;
    if (line >= 8'(FirstVblankLine)) begin
      m = MODE_VBLANK;
    end else if (dots < 9'(DotsOam)) begin
      m = MODE_OAM;
    end else if (dots < 9'(DotsOam + DotsXfer)) begin
      m = MODE_XFER;
    end else begin
      m = MODE_HBLANK;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/lsms_in_stage.sv
// Input register for the LCD scanline mode sequencer: holds one request for the core.
// Depends on lsms_pkg.
module lsms_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lsms_pkg::InDataW-1:0] s_tdata,
  input  logic                        take,
  output logic                        item_valid,
  output lsms_pkg::item_t             item
);
  import lsms_pkg::*;

  // Refill in the same cycle the core consumes the held request.
  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_t'(s_tdata[$bits(item_t)-1:0]);
    end
  end

endmodule

>>> hw/rtl/lsms_core.sv
// Dot/line/mode state, next-state logic and result register of the sequencer.
// Depends on lsms_pkg and lcd_scanline_mode_sequencer_top_defines.svh.
`include "lcd_scanline_mode_sequencer_top_defines.svh"

module lsms_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  lsms_pkg::item_t              item,
  output logic                         take,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lsms_pkg::OutDataW-1:0] m_tdata
);
  import lsms_pkg::*;

  logic [8:0] dot_count;
  logic [7:0] line_count;
  mode_t      current_mode;
  logic       match_flag;

  logic [8:0] dot_count_next;
  logic [7:0] line_count_next;
  mode_t      current_mode_next;
  logic       match_flag_next;
  logic       stat_irq_next;
  logic       vblank_irq_next;

  logic [9:0] dot_sum;
  logic       wrap;
  logic [7:0] line_inc;
  logic [7:0] line_on;
  logic [8:0] dot_on;
  logic       match_on;
  mode_t      mode_on;
  logic       entered;

  assign take = item_valid && (!m_tvalid || m_tready);

  always_comb begin
    // dot_count stays below one line, so a single subtract handles the wrap
    dot_sum  = {1'b0, dot_count} + {2'b00, item.elapsed_cycles};
    wrap     = dot_sum >= 10'(DotsLine);
    dot_on   = wrap ? 9'(dot_sum - 10'(DotsLine)) : dot_sum[8:0];
    line_inc = (line_count == 8'(LinesPerFrame - 1)) ? 8'd0 : line_count + 8'd1;
    line_on  = wrap ? line_inc : line_count;
    match_on = wrap ? (line_on == item.compare_line) : match_flag;
    mode_on  = mode_for(line_on, dot_on);
    entered  = mode_on != current_mode;

    if (item.lcd_on) begin
      dot_count_next    = dot_on;
      line_count_next   = line_on;
      current_mode_next = mode_on;
      match_flag_next   = match_on;
      stat_irq_next     = (wrap && match_on && item.match_irq_enable) ||
                          (entered && mode_on == MODE_OAM && item.oam_irq_enable) ||
                          (entered && mode_on == MODE_HBLANK && item.hblank_irq_enable);
      vblank_irq_next   = entered && mode_on == MODE_VBLANK;
    end else begin
      dot_count_next    = 9'd0;
      line_count_next   = 8'd0;
      current_mode_next = MODE_HBLANK;
      match_flag_next   = match_flag;
      stat_irq_next     = 1'b0;
      vblank_irq_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count    <= 9'd0;
      line_count   <= 8'd0;
      current_mode <= MODE_HBLANK;
      match_flag   <= 1'b0;
    end else if (take) begin
      dot_count    <= dot_count_next;
      line_count   <= line_count_next;
      current_mode <= current_mode_next;
      match_flag   <= match_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {3'b000, vblank_irq_next, stat_irq_next, match_flag_next,
                  line_count_next, current_mode_next};
    end
  end

  `LSMS_ASSERT_IMPL(a_line_range, 1'b1, line_count < 8'(LinesPerFrame), "line out of range")
  `LSMS_ASSERT_IMPL(a_dot_range, 1'b1, dot_count < 9'(DotsLine), "dot count out of range")
  `LSMS_ASSERT_IMPL(a_vblank_lines, current_mode == MODE_VBLANK,
                    line_count >= 8'(FirstVblankLine), "vblank mode on a visible line")
  `LSMS_ASSERT_NEXT(a_lcd_off_clears, take && !item.lcd_on,
                    line_count == 8'd0 && dot_count == 9'd0 && current_mode == MODE_HBLANK,
                    "lcd off did not clear the sequencer")
  `LSMS_ASSERT_IMPL(a_vblank_irq_mode, m_tvalid && m_tdata[12],
                    m_tdata[1:0] == MODE_VBLANK, "vblank request outside vblank mode")

endmodule

>>> hw/rtl/lcd_scanline_mode_sequencer_top.sv
// LCD scanline mode sequencer. Each request carries a burst of elapsed dot cycles
// (0..255) and the live LCD enable, compare line and status interrupt enables; each
// produces one result with the mode, line, coincidence flag and one-shot interrupt
// requests. Lines are 456 dots (80 OAM scan, 172 transfer, 204 hblank); lines
// 144..153 are vblank. A request passes an input register and then a result register,
// and one request is taken every cycle while results are taken, set by the single
// add-and-compare on the dot counter. A waiting result holds the request in the input
// register, and s_tready stays low until that result is taken; with the input register
// empty, one more request still enters. LCD off holds line, dots and mode at zero.
// Depends on lsms_pkg, lsms_in_stage, lsms_core.
module lcd_scanline_mode_sequencer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // elapsed_cycles[7:0], lcd_on[8], compare_line[16:9], oam_irq_enable[17],
  // hblank_irq_enable[18], match_irq_enable[19], zero pad [23:20]
  input  logic [lsms_pkg::InDataW-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // mode[1:0], line[9:2], coincidence[10], stat_irq[11], vblank_irq[12], zero pad [15:13]
  output logic [lsms_pkg::OutDataW-1:0] m_tdata
);
  import lsms_pkg::*;

  logic  take;
  logic  item_valid;
  item_t item;

  lsms_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lsms_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
